/* hw/rtl/fwpf_pkg.sv */
// Shared constants, types and register codes of the four-write-port queue.
package fwpf_pkg;

    // Queue geometry and word width.
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int NUM_LANES  = 4;

    // Derived widths.
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int RANK_W = $clog2(NUM_LANES + 1);
    localparam int SUM_W  = CNT_W + 2;

    // Configuration port.
    localparam int CAP_W      = 5;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CMP_W      = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY    = 1'b1;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef logic [DATA_WIDTH-1:0] t_word;

    // One lane's write into the entry store.
    typedef struct packed {
        logic             en;
        logic [PTR_W-1:0] idx;
        t_word            word;
    } t_lane_wr;

endpackage

/* hw/rtl/fwpf_lane.sv */
// One write lane: works out whether its slot is stored and at which entry.
module fwpf_lane (
    input  logic                      i_valid,
    input  fwpf_pkg::t_word           i_word,
    input  logic [fwpf_pkg::RANK_W-1:0] i_rank,
    input  logic                      i_skip_first,
    input  logic [fwpf_pkg::PTR_W-1:0] i_head,
    input  logic [fwpf_pkg::CNT_W-1:0] i_count,
    input  logic [fwpf_pkg::CNT_W-1:0] i_count_pop,
    input  logic [fwpf_pkg::CNT_W-1:0] i_limit,
    output fwpf_pkg::t_lane_wr        o_wr
);
    import fwpf_pkg::*;

    logic              bypassed;
    logic [RANK_W-1:0] pos;
    logic [SUM_W-1:0]  fill;
    logic [SUM_W-1:0]  slot_raw;
    logic [SUM_W-1:0]  slot;

    // The first valid write is consumed by the reader when it was bypassed.
    assign bypassed = i_skip_first && (i_rank == '0);
    assign pos      = i_rank - RANK_W'(i_skip_first);

    // Appends stop once the stored count reaches the limit.
    assign fill = SUM_W'(i_count_pop) + SUM_W'(pos);

    // Head plus count is the tail both before and after a pop.
    assign slot_raw = SUM_W'(i_head) + SUM_W'(i_count) + SUM_W'(pos);
    assign slot     = (slot_raw >= SUM_W'(DEPTH)) ? slot_raw - SUM_W'(DEPTH) : slot_raw;

    always_comb begin
        o_wr.en   = i_valid && !bypassed && (fill < SUM_W'(i_limit));
        o_wr.idx  = slot[PTR_W-1:0];
        o_wr.word = i_word;
    end

endmodule

/* hw/rtl/fwpf_store.sv */
// Entry store with head pointer and count; merges the lane writes.
module fwpf_store (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic                       i_pop,
    input  fwpf_pkg::t_lane_wr         i_lane_wr [fwpf_pkg::NUM_LANES],
    output fwpf_pkg::t_word            o_head_word,
    output logic [fwpf_pkg::PTR_W-1:0] o_head,
    output logic [fwpf_pkg::CNT_W-1:0] o_count
);
    import fwpf_pkg::*;

    t_word             r_store [DEPTH];
    logic [PTR_W-1:0]  r_head;
    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  n_head;
    logic [CNT_W-1:0]  n_count;
    logic [RANK_W-1:0] stored;

    assign o_head_word = r_store[r_head];
    assign o_head      = r_head;
    assign o_count     = r_count;

    // Number of lanes that store this beat.
    always_comb begin
        stored = '0;
        for (int k = 0; k < NUM_LANES; k++) begin
            stored = stored + RANK_W'(i_lane_wr[k].en);
        end
    end

    // Pointer and count updates.
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_adv) begin
            if (i_pop) begin
                n_head = (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + PTR_W'(1);
            end
            n_count = r_count - CNT_W'(i_pop) + CNT_W'(stored);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Merge the lane writes; lanes of one beat never share an entry.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int e = 0; e < DEPTH; e++) begin
                for (int k = 0; k < NUM_LANES; k++) begin
                    if (i_lane_wr[k].en && (i_lane_wr[k].idx == PTR_W'(e))) begin
                        r_store[e] <= i_lane_wr[k].word;
                    end
                end
            end
        end
    end

endmodule

/* hw/rtl/four_write_port_fifo_unit.sv */
// Top level of the four-write-port queue with read bypass.
//
//   Channel   Direction  Handshake                   Payload
//   input     in         i_in_valid / o_in_ready     four write slots, read take
//   result    out        o_out_valid / i_out_ready   read word, available, occupancy, full
//   config    in         i_cfg_we                    i_cfg_idx, i_cfg_data
//
// One beat is taken every cycle in which o_in_ready is high; its result appears in
// the output register on the following cycle. The rate is set by the update of
// the entry store, head pointer and count, which all four lanes feed in parallel.
// Reset is synchronous and active low; it empties the queue and restores the
// registers. A stalled result holds the input side only while it is not taken.
module four_write_port_fifo_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_write_valid_0,
    input  fwpf_pkg::t_word                 i_write_word_0,
    input  logic                            i_write_valid_1,
    input  fwpf_pkg::t_word                 i_write_word_1,
    input  logic                            i_write_valid_2,
    input  fwpf_pkg::t_word                 i_write_word_2,
    input  logic                            i_write_valid_3,
    input  fwpf_pkg::t_word                 i_write_word_3,
    input  logic                            i_read_take,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output fwpf_pkg::t_word                 o_read_word,
    output logic                            o_read_available,
    output logic [fwpf_pkg::CNT_W-1:0]      o_occupancy,
    output logic                            o_is_full,
    input  logic                            i_cfg_we,
    input  logic [fwpf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fwpf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fwpf_pkg::*;

    logic [CAP_W-1:0]  r_cap;
    t_word             r_empty;
    logic              r_out_valid;
    t_word             r_read_word;
    logic              r_read_available;
    logic [CNT_W-1:0]  r_occupancy;
    logic              r_is_full;

    logic              adv;
    logic              q_empty;
    logic              pop;
    logic              skip_first;
    logic              any_valid;
    logic [CNT_W-1:0]  limit;
    logic [CNT_W-1:0]  count_pop;
    logic [PTR_W-1:0]  head;
    logic [CNT_W-1:0]  count;
    t_word             head_word;
    t_word             first_word;
    t_word             n_read_word;

    logic              wv   [NUM_LANES];
    t_word             ww   [NUM_LANES];
    logic [RANK_W-1:0] rank [NUM_LANES];
    t_lane_wr          lane_wr [NUM_LANES];

    assign wv[0] = i_write_valid_0;
    assign wv[1] = i_write_valid_1;
    assign wv[2] = i_write_valid_2;
    assign wv[3] = i_write_valid_3;
    assign ww[0] = i_write_word_0;
    assign ww[1] = i_write_word_1;
    assign ww[2] = i_write_word_2;
    assign ww[3] = i_write_word_3;

    // Input handshake: the output register frees up when its beat is taken.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign adv        = i_in_valid && o_in_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RESET;
            r_empty <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CAPACITY: r_cap   <= i_cfg_data[CAP_W-1:0];
                CFG_EMPTY:    r_empty <= DATA_WIDTH'(i_cfg_data);
                default:      r_cap   <= r_cap;
            endcase
        end
    end

    // Effective limit saturates at the queue depth.
    assign limit = (CMP_W'(r_cap) > CMP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(r_cap);

    // Compaction ranks: each slot's place among the valid writes.
    always_comb begin
        rank[0] = '0;
        for (int k = 1; k < NUM_LANES; k++) begin
            rank[k] = rank[k-1] + RANK_W'(wv[k-1]);
        end
    end

    // First valid write, in slot order, for the bypass path.
    always_comb begin
        first_word = ww[NUM_LANES-1];
        for (int k = NUM_LANES - 2; k >= 0; k--) begin
            if (wv[k]) begin
                first_word = ww[k];
            end
        end
    end

    assign any_valid  = wv[0] || wv[1] || wv[2] || wv[3];
    assign q_empty    = (count == '0);
    assign pop        = i_read_take && !q_empty;
    assign skip_first = i_read_take && q_empty;
    assign count_pop  = count - CNT_W'(pop);

    // Write lanes.
    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
        fwpf_lane u_lane (
            .i_valid      (wv[k]),
            .i_word       (ww[k]),
            .i_rank       (rank[k]),
            .i_skip_first (skip_first),
            .i_head       (head),
            .i_count      (count),
            .i_count_pop  (count_pop),
            .i_limit      (limit),
            .o_wr         (lane_wr[k])
        );
    end

    fwpf_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_pop       (pop),
        .i_lane_wr   (lane_wr),
        .o_head_word (head_word),
        .o_head      (head),
        .o_count     (count)
    );

    // Read view at the start of the beat.
    always_comb begin
        if (!q_empty) begin
            n_read_word = head_word;
        end else if (any_valid) begin
            n_read_word = first_word;
        end else begin
            n_read_word = r_empty;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_read_word      <= n_read_word;
            r_read_available <= !q_empty || any_valid;
            r_occupancy      <= count;
            r_is_full        <= (count >= limit);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_read_word      = r_read_word;
    assign o_read_available = r_read_available;
    assign o_occupancy      = r_occupancy;
    assign o_is_full        = r_is_full;

endmodule

/* hw/rtl/fwpf_checker.sv */
// Port-level checks of the four-write-port queue, bound to the top level.
module fwpf_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_in_ready,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  fwpf_pkg::t_word                 o_read_word,
    input  logic                            o_read_available,
    input  logic [fwpf_pkg::CNT_W-1:0]      o_occupancy,
    input  logic                            o_is_full
);
    import fwpf_pkg::*;

    // A result is never shown in the cycle after reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    // A stalled result beat holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_word)
            && $stable(o_occupancy) && $stable(o_is_full))
        else $error("stalled result changed");

    // Occupancy never exceeds the queue depth.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_occupancy <= CNT_W'(DEPTH)))
        else $error("occupancy above depth");

    // A non-empty queue always offers a word.
    a_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_occupancy != '0) |-> o_read_available)
        else $error("stored entries but nothing available");

    // Input is ready whenever the output side is free.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

endmodule

bind four_write_port_fifo_unit fwpf_checker u_fwpf_checker (.*);
